// ===== design/cpcl_pkg.sv =====
// ----------------------------------------------------------------------------
// cpcl_pkg
// Shared widths, register map and reset values of the chassis power
// current limiter.
// ----------------------------------------------------------------------------
package cpcl_pkg;

	// default geometry of the motor current words
	localparam int DEF_MOTOR_COUNT  = 4;
	localparam int DEF_CURRENT_BITS = 16;

	// fixed field widths
	localparam int POWER_W  = 16;
	localparam int ENERGY_W = 16;
	localparam int MAXP_W   = 10;
	localparam int GAIN_W   = 10;
	localparam int PERIOD_W = 8;
	localparam int FALLBACK_W = 16;

	// max_power * gain, and the widest total limit (buffer term * energy)
	localparam int GPROD_W = MAXP_W + GAIN_W;
	localparam int LIM_W   = GPROD_W + ENERGY_W;
	// Q10.6: whole watts shifted up by this many bits
	localparam int FRAC_W  = 6;

	// APB port
	localparam int DATA_W    = 32;
	localparam int REG_COUNT = 7;
	localparam int ADDR_W    = $clog2(REG_COUNT) + 2;

	typedef enum logic [$clog2(REG_COUNT)-1:0] {
		REG_FALLBACK,
		REG_WARN_BUF,
		REG_MIN_BUF,
		REG_BUF_GAIN,
		REG_PWR_GAIN,
		REG_CAP_FIRST,
		REG_CAP_PERIOD
	} reg_idx_t;

	localparam logic [FALLBACK_W-1:0] RST_FALLBACK   = 16'd8000;
	localparam logic [ENERGY_W-1:0]   RST_WARN_BUF   = 16'd3200;
	localparam logic [ENERGY_W-1:0]   RST_MIN_BUF    = 16'd320;
	localparam logic [GAIN_W-1:0]     RST_BUF_GAIN   = 10'd200;
	localparam logic [GAIN_W-1:0]     RST_PWR_GAIN   = 10'd250;
	localparam logic [PERIOD_W-1:0]   RST_CAP_FIRST  = 8'd20;
	localparam logic [PERIOD_W-1:0]   RST_CAP_PERIOD = 8'd10;

	function automatic int max_int(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

endpackage

// ===== design/cpcl_if.sv =====
// ----------------------------------------------------------------------------
// cpcl_cmd_if / cpcl_res_if
// Valid/ready channels carrying one control tick in and one limited
// current word out.
// ----------------------------------------------------------------------------
interface cpcl_cmd_if import cpcl_pkg::*; #(
	parameter int MOTOR_COUNT  = DEF_MOTOR_COUNT,
	parameter int CURRENT_BITS = DEF_CURRENT_BITS
);
	logic                                      valid;
	logic                                      ready;
	logic                                      referee_ok;
	logic                                      cap_ok;
	logic [POWER_W-1:0]                        meas_power;
	logic [ENERGY_W-1:0]                       buffer_energy;
	logic [MAXP_W-1:0]                         max_power;
	// two's complement current commands, one per motor
	logic [MOTOR_COUNT-1:0][CURRENT_BITS-1:0] motor_current;

	modport source (
		output valid, referee_ok, cap_ok, meas_power, buffer_energy, max_power,
		       motor_current,
		input  ready
	);
	modport sink (
		input  valid, referee_ok, cap_ok, meas_power, buffer_energy, max_power,
		       motor_current,
		output ready
	);
endinterface

interface cpcl_res_if import cpcl_pkg::*; #(
	parameter int MOTOR_COUNT  = DEF_MOTOR_COUNT,
	parameter int CURRENT_BITS = DEF_CURRENT_BITS
);
	logic                                      valid;
	logic                                      ready;
	// two's complement limited commands, one per motor
	logic [MOTOR_COUNT-1:0][CURRENT_BITS-1:0] limited_current;
	logic                                      was_limited;
	logic                                      cap_report;
	logic [MAXP_W-1:0]                         cap_power_limit;
	logic [ENERGY_W-1:0]                       cap_buffer;

	modport source (
		output valid, limited_current, was_limited, cap_report, cap_power_limit,
		       cap_buffer,
		input  ready
	);
	modport sink (
		input  valid, limited_current, was_limited, cap_report, cap_power_limit,
		       cap_buffer,
		output ready
	);
endinterface

// ===== design/chassis_power_current_limiter.sv =====
// ----------------------------------------------------------------------------
// chassis_power_current_limiter
// Forms a total current limit from referee power data (or a fallback value when
// the referee is absent) and scales the motor commands so their summed magnitude
// stays within it; also paces the capacitor report.
// ----------------------------------------------------------------------------
// Flow: without referee data the fallback limit goes straight to the compare step;
//   otherwise the limit comes from the shared multiplier and, when needed, the
//   divider (NUM_W = 36 bits by default); each scaled motor takes its own divide.
// Throughput: one word at a time; the one-bit-per-cycle shared divider dominates
//   the work per word. The next word is taken while the last result waits.
// Reset: clears the sequencer and output valid, loads the register reset values.
module chassis_power_current_limiter import cpcl_pkg::*; #(
	parameter int MOTOR_COUNT  = DEF_MOTOR_COUNT,
	parameter int CURRENT_BITS = DEF_CURRENT_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	cpcl_cmd_if.sink          cmd,
	cpcl_res_if.source        res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam int CB      = CURRENT_BITS;
	localparam int TOT_W   = CB + $clog2(MOTOR_COUNT);
	localparam int MUL_A_W = max_int(GPROD_W, TOT_W);
	localparam int MUL_B_W = max_int(ENERGY_W, CB);
	localparam int MUL_W   = MUL_A_W + MUL_B_W;
	localparam int NUM_W   = max_int(LIM_W, CB + TOT_W);
	localparam int DEN_W   = max_int(ENERGY_W, TOT_W);
	localparam int CNT_W   = $clog2(NUM_W);
	localparam int IDX_W   = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_B,
		S_MUL_P,
		S_PICK,
		S_DLOAD,
		S_DIV,
		S_LIM_END,
		S_CMP,
		S_MUL_MOT,
		S_MOT_END,
		S_FIN
	} state_t;

	// ---------------- configuration ----------------
	logic [FALLBACK_W-1:0] fallback_q;
	logic [ENERGY_W-1:0]   warn_buf_q;
	logic [ENERGY_W-1:0]   min_buf_q;
	logic [GAIN_W-1:0]     buf_gain_q;
	logic [GAIN_W-1:0]     pwr_gain_q;
	logic [PERIOD_W-1:0]   cap_first_q;
	logic [PERIOD_W-1:0]   cap_period_q;
	logic [PERIOD_W-1:0]   cap_cnt_q;

	logic     cfg_wr;
	reg_idx_t cfg_idx;
	logic     accept;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_comb begin
		prdata = '0;
		case (cfg_idx)
			REG_FALLBACK:   prdata = DATA_W'(fallback_q);
			REG_WARN_BUF:   prdata = DATA_W'(warn_buf_q);
			REG_MIN_BUF:    prdata = DATA_W'(min_buf_q);
			REG_BUF_GAIN:   prdata = DATA_W'(buf_gain_q);
			REG_PWR_GAIN:   prdata = DATA_W'(pwr_gain_q);
			REG_CAP_FIRST:  prdata = DATA_W'(cap_first_q);
			REG_CAP_PERIOD: prdata = DATA_W'(cap_period_q);
			default:        prdata = '0;
		endcase
	end

	// report countdown: runs on words with cap_ok, reloads when it hits zero
	logic [PERIOD_W-1:0] cap_dec;
	logic                cap_due;

	assign cap_dec = (cap_cnt_q != '0) ? cap_cnt_q - 1'b1 : cap_cnt_q;
	assign cap_due = cmd.cap_ok && (cap_dec == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fallback_q   <= RST_FALLBACK;
			warn_buf_q   <= RST_WARN_BUF;
			min_buf_q    <= RST_MIN_BUF;
			buf_gain_q   <= RST_BUF_GAIN;
			pwr_gain_q   <= RST_PWR_GAIN;
			cap_first_q  <= RST_CAP_FIRST;
			cap_period_q <= RST_CAP_PERIOD;
			cap_cnt_q    <= RST_CAP_FIRST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_FALLBACK:   fallback_q   <= pwdata[FALLBACK_W-1:0];
				REG_WARN_BUF:   warn_buf_q   <= pwdata[ENERGY_W-1:0];
				REG_MIN_BUF:    min_buf_q    <= pwdata[ENERGY_W-1:0];
				REG_BUF_GAIN:   buf_gain_q   <= pwdata[GAIN_W-1:0];
				REG_PWR_GAIN:   pwr_gain_q   <= pwdata[GAIN_W-1:0];
				REG_CAP_FIRST: begin
					cap_first_q <= pwdata[PERIOD_W-1:0];
					cap_cnt_q   <= pwdata[PERIOD_W-1:0];
				end
				REG_CAP_PERIOD: cap_period_q <= pwdata[PERIOD_W-1:0];
				default: ;
			endcase
		end else if (accept && cmd.cap_ok) begin
			cap_cnt_q <= cap_due ? cap_period_q : cap_dec;
		end
	end

	// ---------------- input magnitudes ----------------
	logic [MOTOR_COUNT-1:0]       neg_in;
	logic [CB-1:0]                mag_in [MOTOR_COUNT];
	logic [TOT_W-1:0]             tot_in;

	always_comb begin
		tot_in = '0;
		for (int i = 0; i < MOTOR_COUNT; i++) begin
			neg_in[i] = cmd.motor_current[i][CB-1];
			// most negative code maps to 2^(CB-1) as unsigned
			mag_in[i] = neg_in[i] ? CB'(-cmd.motor_current[i]) : cmd.motor_current[i];
			tot_in    = tot_in + TOT_W'(mag_in[i]);
		end
	end

	// ---------------- sequencer and shared units ----------------
	state_t                 state_q;
	logic                   lim_phase_q;
	logic [POWER_W-1:0]     power_q;
	logic [ENERGY_W-1:0]    buf_q;
	logic [MAXP_W-1:0]      mp_q;
	logic                   rep_q;
	logic [MOTOR_COUNT-1:0] neg_q;
	logic [CB-1:0]          mag_q [MOTOR_COUNT];
	logic [CB-1:0]          cur_q [MOTOR_COUNT];
	logic [TOT_W-1:0]       total_q;
	logic [GPROD_W-1:0]     bterm_q;
	logic [LIM_W-1:0]       add_q;
	logic [LIM_W-1:0]       lim_q;
	logic                   scaled_q;
	logic [IDX_W-1:0]       idx_q;
	logic [MUL_W-1:0]       mul_q;
	logic [NUM_W-1:0]       num_q;
	logic [DEN_W-1:0]       rem_q;
	logic [DEN_W-1:0]       den_q;
	logic [CNT_W-1:0]       dcnt_q;

	logic                   out_valid_q;
	logic [CB-1:0]          out_cur_q [MOTOR_COUNT];
	logic                   out_lim_q;
	logic                   out_rep_q;
	logic [MAXP_W-1:0]      out_pl_q;
	logic [ENERGY_W-1:0]    out_buf_q;

	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == S_IDLE);

	// power decision terms
	logic [MAXP_W-2:0]          half;
	logic [POWER_W-1:0]         half64;
	logic [POWER_W-1:0]         mp64;
	logic [POWER_W-1:0]         pdiff;
	logic [ENERGY_W-1:0]        eff_buf;
	logic [GPROD_W-1:0]         pterm;
	logic                       low_buf;

	assign half    = mp_q[MAXP_W-1:1];
	assign half64  = POWER_W'({half, {FRAC_W{1'b0}}});
	assign mp64    = {mp_q, {FRAC_W{1'b0}}};
	assign pdiff   = mp64 - power_q;
	assign eff_buf = (buf_q > min_buf_q) ? buf_q : min_buf_q;
	assign pterm   = mul_q[GPROD_W-1:0];
	assign low_buf = buf_q < warn_buf_q;

	// shared multiplier operands
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MUL_B: begin
				mul_a = MUL_A_W'(mp_q);
				mul_b = MUL_B_W'(buf_gain_q);
			end
			S_MUL_P: begin
				mul_a = MUL_A_W'(mp_q);
				mul_b = MUL_B_W'(pwr_gain_q);
			end
			S_PICK: begin
				mul_a = low_buf ? MUL_A_W'(bterm_q) : MUL_A_W'(pterm);
				mul_b = low_buf ? MUL_B_W'(eff_buf) : MUL_B_W'(pdiff);
			end
			S_MUL_MOT: begin
				// scaling only runs with limit below total, so it fits TOT_W
				mul_a = MUL_A_W'(lim_q[TOT_W-1:0]);
				mul_b = MUL_B_W'(mag_q[idx_q]);
			end
			default: ;
		endcase
	end

	// restoring divider step, one quotient bit per cycle
	logic [DEN_W:0] rem_sh;
	logic           div_ge;
	logic [DEN_W:0] rem_nx;

	assign rem_sh = {rem_q, num_q[NUM_W-1]};
	assign div_ge = rem_sh >= {1'b0, den_q};
	assign rem_nx = div_ge ? rem_sh - {1'b0, den_q} : rem_sh;

	logic [CB-1:0] quo;
	assign quo = num_q[CB-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			lim_phase_q <= 1'b0;
			scaled_q    <= 1'b0;
			idx_q       <= '0;
			dcnt_q      <= '0;
		end else begin
			// the finish step owns the output register while it runs
			if (res.valid && res.ready && state_q != S_FIN) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						power_q     <= cmd.meas_power;
						buf_q       <= cmd.buffer_energy;
						mp_q        <= cmd.max_power;
						rep_q       <= cap_due;
						neg_q       <= neg_in;
						total_q     <= tot_in;
						lim_phase_q <= 1'b1;
						for (int i = 0; i < MOTOR_COUNT; i++) begin
							mag_q[i] <= mag_in[i];
							cur_q[i] <= cmd.motor_current[i];
						end
						if (!cmd.referee_ok) begin
							lim_q   <= LIM_W'(fallback_q);
							state_q <= S_CMP;
						end else begin
							state_q <= S_MUL_B;
						end
					end
				end
				S_MUL_B: begin
					mul_q   <= MUL_W'(mul_a * mul_b);
					state_q <= S_MUL_P;
				end
				S_MUL_P: begin
					bterm_q <= mul_q[GPROD_W-1:0];
					mul_q   <= MUL_W'(mul_a * mul_b);
					state_q <= S_PICK;
				end
				S_PICK: begin
					if (low_buf) begin
						mul_q   <= MUL_W'(mul_a * mul_b);
						den_q   <= DEN_W'(warn_buf_q);
						add_q   <= '0;
						state_q <= S_DLOAD;
					end else if (power_q <= half64) begin
						lim_q   <= LIM_W'(bterm_q) + LIM_W'(pterm);
						state_q <= S_CMP;
					end else if (power_q >= mp64 || half == '0) begin
						lim_q   <= LIM_W'(bterm_q);
						state_q <= S_CMP;
					end else begin
						// power term shrinks linearly between half and full power
						mul_q   <= MUL_W'(mul_a * mul_b);
						den_q   <= DEN_W'(half64);
						add_q   <= LIM_W'(bterm_q);
						state_q <= S_DLOAD;
					end
				end
				S_DLOAD: begin
					num_q   <= mul_q[NUM_W-1:0];
					rem_q   <= '0;
					dcnt_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					num_q  <= {num_q[NUM_W-2:0], div_ge};
					rem_q  <= rem_nx[DEN_W-1:0];
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == CNT_W'(NUM_W - 1))
						state_q <= lim_phase_q ? S_LIM_END : S_MOT_END;
				end
				S_LIM_END: begin
					lim_q   <= add_q + num_q[LIM_W-1:0];
					state_q <= S_CMP;
				end
				S_CMP: begin
					lim_phase_q <= 1'b0;
					idx_q       <= '0;
					if (LIM_W'(total_q) > lim_q) begin
						scaled_q <= 1'b1;
						den_q    <= DEN_W'(total_q);
						state_q  <= S_MUL_MOT;
					end else begin
						scaled_q <= 1'b0;
						state_q  <= S_FIN;
					end
				end
				S_MUL_MOT: begin
					mul_q   <= MUL_W'(mul_a * mul_b);
					state_q <= S_DLOAD;
				end
				S_MOT_END: begin
					cur_q[idx_q] <= neg_q[idx_q] ? CB'(-quo) : quo;
					if (idx_q == IDX_W'(MOTOR_COUNT - 1)) begin
						state_q <= S_FIN;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_MUL_MOT;
					end
				end
				S_FIN: begin
					if (!out_valid_q || res.ready) begin
						out_valid_q <= 1'b1;
						for (int i = 0; i < MOTOR_COUNT; i++) out_cur_q[i] <= cur_q[i];
						out_lim_q <= scaled_q;
						out_rep_q <= rep_q;
						out_pl_q  <= rep_q ? mp_q : '0;
						out_buf_q <= rep_q ? buf_q : '0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.valid = out_valid_q;
	always_comb begin
		for (int i = 0; i < MOTOR_COUNT; i++) res.limited_current[i] = out_cur_q[i];
	end
	assign res.was_limited     = out_lim_q;
	assign res.cap_report      = out_rep_q;
	assign res.cap_power_limit = out_pl_q;
	assign res.cap_buffer      = out_buf_q;

	// ---------------- checks ----------------
	a_div_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> den_q != '0)
		else $error("divider running with zero divisor");

	a_one_word_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !cmd.ready)
		else $error("new word taken while one is in work");

	a_scaled_not_larger: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MOT_END |-> num_q <= NUM_W'(mag_q[idx_q]))
		else $error("scaled magnitude exceeds the command");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FIN))
		else $error("result raised outside the finish step");

endmodule
